FILE: rtl/rrdt_pkg.sv
`timescale 1ns / 1ps

package rrdt_pkg;

	// Result status codes.
	localparam logic [1:0] STATUS_FOUND    = 2'd0;
	localparam logic [1:0] STATUS_INSERTED = 2'd1;
	localparam logic [1:0] STATUS_FULL     = 2'd2;

	// Largest address that fits a single entry without a continuation.
	localparam logic [30:0] SHORT_LIMIT = 31'h0000_ffff;

	typedef struct packed {
		logic [23:0] line_id;
		logic [15:0] street_id;
		logic [15:0] zip_id;
		logic [15:0] city_id;
		logic [30:0] from_address;
		logic [30:0] to_address;
	} rec_t;

	typedef struct packed {
		logic [9:0] entry_index;
		logic [1:0] status;
		logic       extended;
	} res_t;

	// One table entry: the record plus its flags.
	typedef struct packed {
		rec_t rec;
		logic ext;
		logic head;
	} entry_t;

endpackage

FILE: rtl/range_record_dedup_table_core.sv
`timescale 1ns / 1ps

// Deduplicating range record table. Each record beat is searched against the
// stored head entries by a linear walk through a single-port-read memory, one
// entry per cycle. One record is in flight at a time; a finished result sits
// in an output register while the next record is taken. A miss appends the
// record (two entries if either address exceeds 16 bits) or reports the table
// full and writes nothing. The table needs no clearing after reset, as only
// entries below the fill count are ever read.
module range_record_dedup_table_core #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rec_valid,
	output logic                rec_ready,
	input  rrdt_pkg::rec_t      rec,
	output logic                res_valid,
	input  logic                res_ready,
	output rrdt_pkg::res_t      res
);

	localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	logic              mem_we;
	logic [IW-1:0]     mem_waddr;
	rrdt_pkg::entry_t  mem_wdata;
	logic              mem_re;
	logic [IW-1:0]     mem_raddr;
	rrdt_pkg::entry_t  mem_rdata;
	logic [CW-1:0]     entry_count;

	rrdt_mem #(
		.DEPTH (TABLE_DEPTH),
		.IW    (IW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	rrdt_ctrl #(
		.DEPTH (TABLE_DEPTH),
		.IW    (IW),
		.CW    (CW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.rec_valid   (rec_valid),
		.rec_ready   (rec_ready),
		.rec         (rec),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_re      (mem_re),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata),
		.entry_count (entry_count)
	);

`ifndef SYNTHESIS
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_valid && rec_ready) |=> !rec_ready)
		else $error("record taken while another is in flight");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, entry_count} <= (CW+1)'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.status == rrdt_pkg::STATUS_FULL)) |->
		((res.entry_index == '0) && !res.extended))
		else $error("full result carries an index or extension");

	a_found_result: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.status == rrdt_pkg::STATUS_FOUND)) |-> !res.extended)
		else $error("found result flagged as extended");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rec_ready |-> !mem_we)
		else $error("table written while idle");
`endif

endmodule

FILE: rtl/rrdt_mem.sv
`timescale 1ns / 1ps

module rrdt_mem #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned IW    = 10
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [IW-1:0]         waddr,
	input  rrdt_pkg::entry_t      wdata,
	input  logic                  re,
	input  logic [IW-1:0]         raddr,
	output rrdt_pkg::entry_t      rdata
);

	rrdt_pkg::entry_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/rrdt_ctrl.sv
`timescale 1ns / 1ps

module rrdt_ctrl #(
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned IW    = 10,
	parameter int unsigned CW    = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rec_valid,
	output logic                  rec_ready,
	input  rrdt_pkg::rec_t        rec,
	output logic                  res_valid,
	input  logic                  res_ready,
	output rrdt_pkg::res_t        res,
	output logic                  mem_we,
	output logic [IW-1:0]         mem_waddr,
	output rrdt_pkg::entry_t      mem_wdata,
	output logic                  mem_re,
	output logic [IW-1:0]         mem_raddr,
	input  rrdt_pkg::entry_t      mem_rdata,
	output logic [CW-1:0]         entry_count
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_SCAN = 4'b0010,
		ST_CONT = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     ptr_q;
	logic              rd_valid_s1;
	logic [IW-1:0]     rd_idx_s1;
	logic [IW-1:0]     base_q;
	logic              wide_q;
	logic              res_valid_q;
	rrdt_pkg::rec_t    item_q;
	rrdt_pkg::res_t    hold_q;
	rrdt_pkg::res_t    res_q;

	logic              issue;
	logic              hit;
	logic              miss;
	logic              room;
	logic              out_free;
	logic              rec_wide;
	logic [CW:0]       need_sum;

	assign rec_wide = (rec.from_address > rrdt_pkg::SHORT_LIMIT) ||
	                  (rec.to_address > rrdt_pkg::SHORT_LIMIT);

	assign issue = (state_q == ST_SCAN) && (ptr_q < count_q);
	assign hit   = (state_q == ST_SCAN) && rd_valid_s1 && mem_rdata.head &&
	               (mem_rdata.rec == item_q);
	assign miss  = (state_q == ST_SCAN) && !issue && !hit;

	assign need_sum = {1'b0, count_q} + (wide_q ? (CW+1)'(2) : (CW+1)'(1));
	assign room     = need_sum <= (CW+1)'(DEPTH);
	assign out_free = !res_valid_q || res_ready;

	assign mem_re    = issue;
	assign mem_raddr = ptr_q[IW-1:0];

	// The head goes in on the cycle the search misses; a continuation follows.
	assign mem_we    = (miss && room) || (state_q == ST_CONT);
	assign mem_waddr = (state_q == ST_CONT) ? base_q + IW'(1) : count_q[IW-1:0];
	always_comb begin
		mem_wdata.rec  = item_q;
		mem_wdata.head = (state_q != ST_CONT);
		mem_wdata.ext  = (state_q != ST_CONT) && wide_q;
	end

	assign rec_ready   = (state_q == ST_IDLE);
	assign res_valid   = res_valid_q;
	assign res         = res_q;
	assign entry_count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			ptr_q       <= '0;
			rd_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= issue && !hit;
			if ((state_q == ST_DONE) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (rec_valid) begin
						ptr_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						ptr_q <= ptr_q + CW'(1);
					end
					if (hit) begin
						state_q <= ST_DONE;
					end else if (miss) begin
						if (room) begin
							count_q <= need_sum[CW-1:0];
							state_q <= wide_q ? ST_CONT : ST_DONE;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_CONT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= ptr_q[IW-1:0];
		if (rec_ready && rec_valid) begin
			item_q <= rec;
			wide_q <= rec_wide;
		end
		if (hit) begin
			hold_q.entry_index <= 10'(rd_idx_s1);
			hold_q.status      <= rrdt_pkg::STATUS_FOUND;
			hold_q.extended    <= 1'b0;
		end else if (miss) begin
			base_q <= count_q[IW-1:0];
			if (room) begin
				hold_q.entry_index <= 10'(count_q[IW-1:0]);
				hold_q.status      <= rrdt_pkg::STATUS_INSERTED;
				hold_q.extended    <= wide_q;
			end else begin
				hold_q.entry_index <= '0;
				hold_q.status      <= rrdt_pkg::STATUS_FULL;
				hold_q.extended    <= 1'b0;
			end
		end
		if ((state_q == ST_DONE) && out_free) begin
			res_q <= hold_q;
		end
	end

endmodule

FILE: sim/rrdt_dedup_checker.sv
`timescale 1ns / 1ps

module rrdt_dedup_checker #(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rec_valid,
	input  logic           rec_ready,
	input  rrdt_pkg::rec_t rec,
	input  logic           res_valid,
	input  logic           res_ready,
	input  rrdt_pkg::res_t res,
	output int             mismatches,
	output int             pending,
	output int             found_count,
	output int             insert_count,
	output int             ext_count,
	output int             full_count
);

	rrdt_pkg::entry_t table_mem [TABLE_DEPTH];
	int unsigned      fill;
	rrdt_pkg::res_t   awaited_results [$];
	int               errors;
	int               result_beats;
	int               n_found;
	int               n_insert;
	int               n_ext;
	int               n_full;

	// Walks the head entries in order; a miss appends the record if it fits, with
	// a continuation entry behind it when either address needs more than 16 bits.
	function automatic rrdt_pkg::res_t lookup_or_append(input rrdt_pkg::rec_t r);
		rrdt_pkg::res_t outcome;
		logic           wide;
		int unsigned    need;
		int             hit;
		wide = (r.from_address > rrdt_pkg::SHORT_LIMIT) ||
			(r.to_address > rrdt_pkg::SHORT_LIMIT);
		need = wide ? 2 : 1;
		hit = -1;
		for (int i = 0; i < int'(fill); i++)
			if (hit < 0 && table_mem[i].head && table_mem[i].rec == r)
				hit = i;
		outcome.extended = 1'b0;
		if (hit >= 0) begin
			outcome.entry_index = 10'(hit);
			outcome.status = rrdt_pkg::STATUS_FOUND;
			n_found++;
		end else if (fill + need > TABLE_DEPTH) begin
			outcome.entry_index = '0;
			outcome.status = rrdt_pkg::STATUS_FULL;
			n_full++;
		end else begin
			table_mem[fill].rec = r;
			table_mem[fill].ext = wide;
			table_mem[fill].head = 1'b1;
			if (wide) begin
				table_mem[fill + 1].rec = r;
				table_mem[fill + 1].ext = 1'b0;
				table_mem[fill + 1].head = 1'b0;
				n_ext++;
			end
			outcome.entry_index = 10'(fill);
			outcome.status = rrdt_pkg::STATUS_INSERTED;
			outcome.extended = wide;
			fill += need;
			n_insert++;
		end
		return outcome;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		rrdt_pkg::res_t want;
		if (!arst_n) begin
			awaited_results.delete();
			fill = 0;
			errors = 0;
			result_beats = 0;
			n_found = 0;
			n_insert = 0;
			n_ext = 0;
			n_full = 0;
			mismatches <= 0;
			pending <= 0;
			found_count <= 0;
			insert_count <= 0;
			ext_count <= 0;
			full_count <= 0;
		end else begin
			// The result side is checked first, so a beat can never be paired
			// with the record accepted at the same edge.
			if (res_valid && res_ready) begin
				result_beats++;
				if (awaited_results.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("beat %0d unexpected: index %0d status %0d ext %0b",
							result_beats, res.entry_index, res.status, res.extended);
				end else begin
					want = awaited_results.pop_front();
					if (res.entry_index !== want.entry_index ||
							res.status !== want.status ||
							res.extended !== want.extended) begin
						errors++;
						if (errors <= 10)
							$display("beat %0d: expected %0d/%0d/%0b, got %0d/%0d/%0b",
								result_beats, want.entry_index, want.status,
								want.extended, res.entry_index, res.status,
								res.extended);
					end
				end
			end
			if (rec_valid && rec_ready)
				awaited_results.push_back(lookup_or_append(rec));
			mismatches <= errors;
			pending <= awaited_results.size();
			found_count <= n_found;
			insert_count <= n_insert;
			ext_count <= n_ext;
			full_count <= n_full;
		end
	end

endmodule

FILE: sim/tb_range_record_dedup_table_core.sv
`timescale 1ns / 1ps

module tb_range_record_dedup_table_core;

	localparam int unsigned TABLE_DEPTH = 1024;
	localparam int RANDOM_ITEMS = 1200;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = TABLE_DEPTH + 16;

	typedef enum int {PICK_REPEAT, PICK_MUTATE, PICK_FRESH} pick_t;

	logic           clk;
	logic           arst_n;
	logic           rec_valid;
	logic           rec_ready;
	rrdt_pkg::rec_t rec;
	logic           res_valid;
	logic           res_ready;
	rrdt_pkg::res_t res;

	int mismatches;
	int pending;
	int found_count;
	int insert_count;
	int ext_count;
	int full_count;

	rrdt_pkg::rec_t sent_log [$];
	int             burst_left = 0;
	int             idle_cycles = 0;

	range_record_dedup_table_core #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.rec_valid(rec_valid),
		.rec_ready(rec_ready),
		.rec(rec),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	rrdt_dedup_checker #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.rec_valid(rec_valid),
		.rec_ready(rec_ready),
		.rec(rec),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.mismatches(mismatches),
		.pending(pending),
		.found_count(found_count),
		.insert_count(insert_count),
		.ext_count(ext_count),
		.full_count(full_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// The receiver cycles through modes: always ready, coin toss, one beat in
	// four, and a long stall released only at the end of the stretch.
	initial begin : receiver
		int mode;
		int len;
		res_ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(5, 60);
			for (int k = 0; k < len; k++) begin
				@(posedge clk);
				case (mode)
					0: begin
						res_ready <= 1'b1;
					end
					1: begin
						res_ready <= 1'($urandom_range(0, 1));
					end
					2: begin
						res_ready <= (k % 4 == 3);
					end
					default: begin
						res_ready <= (k >= len - 2);
					end
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((rec_valid && rec_ready) || (res_valid && res_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("No beat on either channel for %0d cycles.", WATCHDOG_LIMIT);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	task automatic pause_sender(input int cycles);
		if (cycles > 0) begin
			rec_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Valid is left high after the beat so that back-to-back records need
	// no second assignment in the same step.
	task automatic send_record(input rrdt_pkg::rec_t r);
		rec <= r;
		rec_valid <= 1'b1;
		do @(posedge clk); while (!rec_ready);
		sent_log.push_back(r);
	endtask

	task automatic offer(input rrdt_pkg::rec_t r);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 40 : 8);
			pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15));
		end
		send_record(r);
		burst_left--;
	endtask

	task automatic wait_all_results();
		rec_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [30:0] short_address();
		return 31'($urandom_range(0, 32'h0000_ffff));
	endfunction

	// Mostly fresh records, many of them wide, so the table fills part way
	// through the run; the rest are exact repeats or one-bit variants.
	function automatic rrdt_pkg::rec_t make_record();
		rrdt_pkg::rec_t r;
		pick_t          pick;
		int             roll;
		roll = $urandom_range(0, 99);
		if (sent_log.size() == 0 || roll >= 35)
			pick = PICK_FRESH;
		else if (roll < 25)
			pick = PICK_REPEAT;
		else
			pick = PICK_MUTATE;
		if (pick != PICK_FRESH)
			r = sent_log[$urandom_range(0, sent_log.size() - 1)];
		if (pick == PICK_MUTATE) begin
			case ($urandom_range(0, 5))
				0: r.line_id[$urandom_range(0, 23)] ^= 1'b1;
				1: r.street_id[$urandom_range(0, 15)] ^= 1'b1;
				2: r.zip_id[$urandom_range(0, 15)] ^= 1'b1;
				3: r.city_id[$urandom_range(0, 15)] ^= 1'b1;
				4: r.from_address[$urandom_range(0, 30)] ^= 1'b1;
				default: r.to_address[$urandom_range(0, 30)] ^= 1'b1;
			endcase
		end else if (pick == PICK_FRESH) begin
			// Small line numbers build chains of entries sharing a line.
			r.line_id = ($urandom_range(0, 1) == 1) ?
				24'($urandom_range(0, 7)) : 24'($urandom);
			r.street_id = 16'($urandom);
			r.zip_id = 16'($urandom);
			r.city_id = 16'($urandom);
			r.from_address = short_address();
			r.to_address = short_address();
			case ($urandom_range(0, 9))
				0, 1: r.from_address = 31'($urandom);
				2, 3: r.to_address = 31'($urandom);
				4: begin
					r.from_address = 31'($urandom);
					r.to_address = 31'($urandom);
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	initial begin : stimulus
		rrdt_pkg::rec_t probe;
		rec_valid = 1'b0;
		rec = '0;
		do @(posedge clk); while (!arst_n);

		probe = '0;
		offer(probe);
		offer(probe);
		probe = '1;
		offer(probe);
		offer(probe);
		probe = '{line_id: 24'h123456, street_id: 16'h0001, zip_id: 16'h0002,
			city_id: 16'h0003, from_address: rrdt_pkg::SHORT_LIMIT,
			to_address: rrdt_pkg::SHORT_LIMIT};
		offer(probe);
		offer(probe);
		probe.from_address = rrdt_pkg::SHORT_LIMIT + 31'd1;
		probe.to_address = '0;
		offer(probe);
		probe.from_address = '0;
		probe.to_address = rrdt_pkg::SHORT_LIMIT + 31'd1;
		offer(probe);
		offer(probe);
		for (int f = 0; f < 6; f++) begin
			probe = '0;
			case (f)
				0: probe.line_id = 24'd1;
				1: probe.street_id = 16'd1;
				2: probe.zip_id = 16'd1;
				3: probe.city_id = 16'd1;
				4: probe.from_address = 31'd1;
				default: probe.to_address = 31'd1;
			endcase
			offer(probe);
		end
		// The all-ones record again, after its continuation entry was passed.
		probe = '1;
		offer(probe);
		probe = '0;
		offer(probe);
		wait_all_results();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			offer(make_record());
			if (n == RANDOM_ITEMS / 2)
				wait_all_results();
		end
		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d records: %0d matched a stored head, %0d appended",
			sent_log.size(), found_count, insert_count);
		$display("(%0d with a continuation), %0d refused on a full table, %0d mismatches.",
			ext_count, full_count, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
